>>> sv/block_bitmap_allocator_top_defines.svh
// Assertion macros used by the allocator's control module.
`ifndef BLOCK_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bba_pkg.sv
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int MAX_ALLOC_DEF  = 16;

    localparam int LIM_W = 11;

    localparam logic [2:0] CMD_FORMAT = 3'd0;
    localparam logic [2:0] CMD_SET    = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_TEST   = 3'd3;
    localparam logic [2:0] CMD_ALLOC  = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    localparam logic [7:0]       FORMAT_BYTE0 = 8'hC0;
    localparam logic [LIM_W-1:0] TOTAL_RESET  = 11'd1024;

    typedef struct packed {
        logic [2:0] cmd;
        logic [9:0] block_number;
        logic [4:0] alloc_count;
    } in_item_t;

    typedef struct packed {
        logic [9:0] result_block;
        logic       bit_value;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIT,
        ST_ALLOC,
        ST_ONE
    } state_t;

    function automatic logic [7:0] bit_mask(input logic [2:0] pos);
        return 8'h80 >> pos;
    endfunction

endpackage

>>> sv/bba_map_ram.sv
module bba_map_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/bba_out_reg.sv
module bba_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  bba_pkg::out_item_t load_item,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output bba_pkg::out_item_t m_item
);

    import bba_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t item_reg, item_next;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (load) begin
            valid_next = 1'b1;
            item_next  = load_item;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

>>> sv/bba_ctrl.sv
`include "block_bitmap_allocator_top_defines.svh"

module bba_ctrl #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_ALLOC  = bba_pkg::MAX_ALLOC_DEF,
    parameter int MAP_BYTES  = (NUM_BLOCKS + 7) / 8,
    parameter int AW         = $clog2(MAP_BYTES)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [bba_pkg::LIM_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  bba_pkg::in_item_t         s_item,
    input  logic                      out_free,
    output logic                      out_load,
    output bba_pkg::out_item_t        out_item,
    output logic                      rd_en,
    output logic [AW-1:0]             rd_addr,
    input  logic [7:0]                rd_data,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic [7:0]                wr_data
);

    import bba_pkg::*;

    localparam int CW = $clog2(MAX_ALLOC + 1);

    state_t           state_reg, state_next;
    logic [LIM_W-1:0] total_blocks_reg, total_blocks_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic             clr_reply_reg, clr_reply_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [9:0]       blk_reg, blk_next;
    logic [CW-1:0]    want_reg, want_next;
    logic [CW-1:0]    got_reg, got_next;
    logic [LIM_W-1:0] base_reg, base_next;
    logic [7:0]       byte_reg, byte_next;
    logic             fresh_reg, fresh_next;
    logic [1:0]       one_stat_reg, one_stat_next;

    logic [LIM_W-1:0] limit;
    logic [CW-1:0]    want_in;
    logic             clr_done;
    logic [7:0]       bit_m;
    logic             in_range;
    logic [7:0]       bit_byte;
    logic [7:0]       cur_byte;
    logic [7:0]       cand;
    logic             hit;
    logic [2:0]       hit_pos;
    logic [LIM_W-1:0] grant_blk;
    logic [7:0]       upd_byte;
    logic             last_grant;
    logic [LIM_W:0]   next_base;
    logic             scan_end;

    assign limit   = (32'(total_blocks_reg) > NUM_BLOCKS) ? LIM_W'(NUM_BLOCKS)
                                                           : total_blocks_reg;
    assign want_in = (32'(s_item.alloc_count) > MAX_ALLOC) ? CW'(MAX_ALLOC)
                                                            : CW'(s_item.alloc_count);
    assign clr_done = (clr_addr_reg == AW'(MAP_BYTES - 1));

    assign bit_m    = bit_mask(blk_reg[2:0]);
    assign in_range = ({1'b0, blk_reg} < limit);

    always_comb begin
        case (cmd_reg)
            CMD_SET:   bit_byte = rd_data | bit_m;
            CMD_CLEAR: bit_byte = rd_data & ~bit_m;
            default:   bit_byte = rd_data;
        endcase
    end

    assign cur_byte = fresh_reg ? rd_data : byte_reg;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            cand[i] = !cur_byte[7-i] && (({1'b0, base_reg} + 12'(i)) < {1'b0, limit});
        end
        hit_pos = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (cand[i]) begin
                hit_pos = 3'(i);
            end
        end
    end

    assign hit        = |cand;
    assign grant_blk  = base_reg + LIM_W'(hit_pos);
    assign upd_byte   = cur_byte | bit_mask(hit_pos);
    assign last_grant = ((got_reg + CW'(1)) == want_reg);
    assign next_base  = {1'b0, base_reg} + 12'd8;
    assign scan_end   = (next_base >= {1'b0, limit});

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_done) begin
                    state_next = clr_reply_reg ? ST_ONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_item.cmd)
                        CMD_FORMAT: state_next = ST_CLEAR;
                        CMD_SET:    state_next = ST_BIT;
                        CMD_CLEAR:  state_next = ST_BIT;
                        CMD_TEST:   state_next = ST_BIT;
                        CMD_ALLOC:  state_next = (want_in == '0) ? ST_ONE : ST_ALLOC;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ALLOC: begin
                if (hit) begin
                    if (out_free && last_grant) begin
                        state_next = ST_IDLE;
                    end
                end else if (scan_end) begin
                    state_next = ST_ONE;
                end
            end
            ST_ONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        total_blocks_next = cfg_wr_en ? cfg_wr_data : total_blocks_reg;
        clr_addr_next     = clr_addr_reg;
        clr_reply_next    = clr_reply_reg;
        cmd_next          = cmd_reg;
        blk_next          = blk_reg;
        want_next         = want_reg;
        got_next          = got_reg;
        base_next         = base_reg;
        byte_next         = byte_reg;
        fresh_next        = fresh_reg;
        one_stat_next     = one_stat_reg;
        s_ready           = 1'b0;
        out_load          = 1'b0;
        out_item          = '0;
        rd_en             = 1'b0;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = '0;
        case (state_reg)
            ST_CLEAR: begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = (clr_addr_reg == '0) ? FORMAT_BYTE0 : 8'h00;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next      = s_item.cmd;
                    blk_next      = s_item.block_number;
                    want_next     = want_in;
                    got_next      = '0;
                    base_next     = '0;
                    fresh_next    = 1'b1;
                    one_stat_next = STAT_OK;
                    clr_addr_next = '0;
                    clr_reply_next = 1'b1;
                    rd_en         = 1'b1;
                    rd_addr       = (s_item.cmd == CMD_ALLOC) ? '0
                                                              : AW'(s_item.block_number >> 3);
                end
            end
            ST_BIT: begin
                out_load = out_free;
                out_item.result_block = blk_reg;
                out_item.bit_value    = in_range && |(bit_byte & bit_m);
                out_item.status       = in_range ? STAT_OK : STAT_RANGE;
                out_item.last         = 1'b1;
                wr_en   = out_free && in_range && (cmd_reg == CMD_SET || cmd_reg == CMD_CLEAR);
                wr_addr = AW'(blk_reg >> 3);
                wr_data = bit_byte;
            end
            ST_ALLOC: begin
                wr_addr    = AW'(base_reg >> 3);
                fresh_next = 1'b0;
                byte_next  = cur_byte;
                if (hit) begin
                    out_load = out_free;
                    out_item.result_block = grant_blk[9:0];
                    out_item.bit_value    = 1'b1;
                    out_item.status       = STAT_OK;
                    out_item.last         = last_grant;
                    if (out_free) begin
                        byte_next = upd_byte;
                        got_next  = got_reg + CW'(1);
                        wr_en     = last_grant;
                        wr_data   = upd_byte;
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_data = cur_byte;
                    if (scan_end) begin
                        one_stat_next = STAT_NOSPACE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(next_base >> 3);
                        base_next  = next_base[LIM_W-1:0];
                        fresh_next = 1'b1;
                    end
                end
            end
            ST_ONE: begin
                out_load = out_free;
                out_item.result_block = '0;
                out_item.bit_value    = 1'b0;
                out_item.status       = one_stat_reg;
                out_item.last         = 1'b1;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            total_blocks_reg <= TOTAL_RESET;
            clr_addr_reg     <= '0;
            clr_reply_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            total_blocks_reg <= total_blocks_next;
            clr_addr_reg     <= clr_addr_next;
            clr_reply_reg    <= clr_reply_next;
        end
        cmd_reg      <= cmd_next;
        blk_reg      <= blk_next;
        want_reg     <= want_next;
        got_reg      <= got_next;
        base_reg     <= base_next;
        byte_reg     <= byte_next;
        fresh_reg    <= fresh_next;
        one_stat_reg <= one_stat_next;
    end

    `BBA_ASSERT_SAME(a_rw_apart, aclk, aresetn, rd_en && wr_en, rd_addr != wr_addr, "map read and write hit the same byte")
    `BBA_ASSERT_SAME(a_got_below_want, aclk, aresetn, state_reg == ST_ALLOC, got_reg < want_reg, "grant count reached the request inside the scan")
    `BBA_ASSERT_NEXT(a_last_ends_alloc, aclk, aresetn, state_reg == ST_ALLOC && out_load && out_item.last, state_reg == ST_IDLE, "allocation did not finish after its final grant")

endmodule

>>> sv/block_bitmap_allocator_top.sv
// First-fit block allocator over a used-block bitmap held in a byte-wide map memory of
// (NUM_BLOCKS+7)/8 entries with a registered read. After reset the map is swept, one byte
// per cycle, while s_ready stays low; byte 0 marks blocks 0 and 1 used and the rest are
// cleared. Format runs the same sweep and then returns its single item. Set, clear and
// test are accepted with the byte read, then do the read-modify-write with the result.
// Allocate is accepted with the read of map byte 0, grants from the current byte and moves
// on to the next byte when it holds no free block, and ends with an out-of-space item when
// too few blocks are free; a count of zero returns one OK item. The scan is bounded by the
// smaller of total_blocks and NUM_BLOCKS. An unknown command is accepted and returns nothing.
// A cycle that presents an item stalls while the output register is still full, and a
// finished item waits there while the next command is accepted.
module block_bitmap_allocator_top #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_ALLOC  = bba_pkg::MAX_ALLOC_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [bba_pkg::LIM_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  bba_pkg::in_item_t         s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output bba_pkg::out_item_t        m_item
);

    import bba_pkg::*;

    localparam int MAP_BYTES = (NUM_BLOCKS + 7) / 8;
    localparam int AW        = $clog2(MAP_BYTES);

    logic          out_free;
    logic          out_load;
    out_item_t     out_item;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    bba_map_ram #(
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_map (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bba_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .MAX_ALLOC  (MAX_ALLOC),
        .MAP_BYTES  (MAP_BYTES),
        .AW         (AW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .out_free    (out_free),
        .out_load    (out_load),
        .out_item    (out_item),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    bba_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .load_item (out_item),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

>>> sim/tb_top.sv
class bitmap_tracker;
    localparam int MAP_BYTES = bba_pkg::NUM_BLOCKS_DEF / 8;
    localparam int IW        = $clog2(MAP_BYTES);

    bit [7:0]           used_map [MAP_BYTES];
    bit [10:0]          total_blocks;
    bit [4:0]           granted_count;
    bba_pkg::out_item_t owed_results [$];
    int                 mismatches;

    function new();
        total_blocks = bba_pkg::TOTAL_RESET;
        mismatches   = 0;
        wipe();
    endfunction

    function void wipe();
        foreach (used_map[i]) used_map[i] = 8'h00;
        used_map[0]   = 8'hC0;
        granted_count = '0;
    endfunction

    function bit is_used(int unsigned b);
        return used_map[IW'(b >> 3)][3'(7 - (b & 7))];
    endfunction

    function void put_bit(int unsigned b, bit v);
        used_map[IW'(b >> 3)][3'(7 - (b & 7))] = v;
    endfunction

    function int unsigned span();
        return (total_blocks < bba_pkg::NUM_BLOCKS_DEF) ? total_blocks : bba_pkg::NUM_BLOCKS_DEF;
    endfunction

    function int pending();
        return owed_results.size();
    endfunction

    function void owe(int unsigned blk, bit v, logic [1:0] st, bit lst);
        bba_pkg::out_item_t r;
        r.result_block = blk[9:0];
        r.bit_value    = v;
        r.status       = st;
        r.last         = lst;
        owed_results.push_back(r);
    endfunction

    // Works out every result item that an accepted command will cause.
    function void take_command(bba_pkg::in_item_t it);
        int unsigned lim;
        int unsigned want;
        int unsigned got;
        int unsigned b;
        lim = span();
        got = 0;
        case (it.cmd)
            bba_pkg::CMD_FORMAT: begin
                wipe();
                owe(0, 1'b0, bba_pkg::STAT_OK, 1'b1);
            end
            bba_pkg::CMD_SET, bba_pkg::CMD_CLEAR, bba_pkg::CMD_TEST: begin
                if (it.block_number >= lim) begin
                    owe(it.block_number, 1'b0, bba_pkg::STAT_RANGE, 1'b1);
                end else begin
                    if (it.cmd == bba_pkg::CMD_SET) begin
                        put_bit(it.block_number, 1'b1);
                    end else if (it.cmd == bba_pkg::CMD_CLEAR) begin
                        put_bit(it.block_number, 1'b0);
                    end
                    owe(it.block_number, is_used(it.block_number), bba_pkg::STAT_OK, 1'b1);
                end
            end
            bba_pkg::CMD_ALLOC: begin
                want = (it.alloc_count > bba_pkg::MAX_ALLOC_DEF) ?
                       bba_pkg::MAX_ALLOC_DEF : it.alloc_count;
                if (want == 0) begin
                    owe(0, 1'b0, bba_pkg::STAT_OK, 1'b1);
                end else begin
                    for (b = 0; b < lim && got < want; b++) begin
                        if (!is_used(b)) begin
                            put_bit(b, 1'b1);
                            got++;
                            owe(b, 1'b1, bba_pkg::STAT_OK, got == want);
                        end
                    end
                    if (got < want) begin
                        owe(0, 1'b0, bba_pkg::STAT_NOSPACE, 1'b1);
                    end
                end
                granted_count = got[4:0];
            end
            default: begin
            end
        endcase
    endfunction

    task report_mismatch(string what);
        mismatches++;
        if (mismatches <= 100) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
    endtask

    task match_result(bba_pkg::out_item_t got);
        bba_pkg::out_item_t want;
        if (owed_results.size() == 0) begin
            report_mismatch($sformatf("unexpected item block %0d bit %0d status %0d last %0d",
                                      got.result_block, got.bit_value, got.status, got.last));
            return;
        end
        want = owed_results.pop_front();
        if (got.result_block !== want.result_block) begin
            report_mismatch($sformatf("result_block %0d, expected %0d",
                                      got.result_block, want.result_block));
        end
        if (got.bit_value !== want.bit_value) begin
            report_mismatch($sformatf("bit_value %0d, expected %0d for block %0d",
                                      got.bit_value, want.bit_value, want.result_block));
        end
        if (got.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d for block %0d",
                                      got.status, want.status, want.result_block));
        end
        if (got.last !== want.last) begin
            report_mismatch($sformatf("last %0d, expected %0d for block %0d",
                                      got.last, want.last, want.result_block));
        end
    endtask

    task flush_leftovers();
        bba_pkg::out_item_t want;
        while (owed_results.size() != 0) begin
            want = owed_results.pop_front();
            report_mismatch($sformatf("item for block %0d status %0d never arrived",
                                      want.result_block, want.status));
        end
    endtask
endclass

module tb_top;
    import bba_pkg::*;

    localparam int          LIMIT_CYCLES   = 1_000_000;
    localparam int          IDLE_WAIT      = 400;
    localparam int          PHASE_ITEMS    = 41;
    localparam logic [2:0]  CMD_LAST_SPARE = 3'd7;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [LIM_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    in_item_t         s_item      = '0;
    logic             m_ready     = 1'b0;
    logic             s_ready;
    logic             m_valid;
    out_item_t        m_item;

    bitmap_tracker book = new();
    bit            steady_flow = 1'b0;
    int unsigned   sink_hold   = 0;
    int unsigned   cycle_count = 0;

    block_bitmap_allocator_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("block_bitmap_allocator_top verification failed");
            $finish;
        end
    end

    // The handshake is sampled on the falling edge ahead of the rising edge at which it completes.
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            book.match_result(m_item);
        end
    end

    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_ready   <= 1'b0;
        end else if (!steady_flow && $urandom_range(0, 99) < 15) begin
            sink_hold <= pause_len() - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic in_item_t mk(logic [2:0] c, int unsigned blk, int unsigned cnt);
        in_item_t it;
        it.cmd          = c;
        it.block_number = blk[9:0];
        it.alloc_count  = cnt[4:0];
        return it;
    endfunction

    task automatic push_cmd(in_item_t it);
        int unsigned gap;
        s_item  <= it;
        s_valid <= 1'b1;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        book.take_command(it);
        gap = (steady_flow || $urandom_range(0, 99) < 50) ? 0 : pause_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (book.pending() != 0);
    endtask

    // Leaves the block idle for a while before a configuration write.
    task automatic settle();
        hold_until_drained();
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_total(logic [LIM_W-1:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        book.total_blocks = v;
    endtask

    function automatic in_item_t random_cmd();
        in_item_t    it;
        int unsigned r;
        int unsigned eff;
        int unsigned hot;
        eff = book.span();
        hot = (eff < 48) ? eff : 48;
        r = $urandom_range(0, 99);
        if (r < 6)       it.cmd = CMD_FORMAT;
        else if (r < 30) it.cmd = CMD_CLEAR;
        else if (r < 42) it.cmd = CMD_SET;
        else if (r < 57) it.cmd = CMD_TEST;
        else if (r < 92) it.cmd = CMD_ALLOC;
        else             it.cmd = 3'($urandom_range(CMD_ALLOC + 1, CMD_LAST_SPARE));
        r = $urandom_range(0, 99);
        if (eff != 0 && r < 70)         it.block_number = 10'($urandom_range(0, hot - 1));
        else if (eff != 0 && r < 85)    it.block_number = 10'($urandom_range(0, eff - 1));
        else if (eff < 1024 && r < 95)  it.block_number = 10'($urandom_range(eff, 1023));
        else                            it.block_number = 10'($urandom_range(0, 1023));
        r = $urandom_range(0, 99);
        if (r < 70)      it.alloc_count = 5'($urandom_range(1, 4));
        else if (r < 85) it.alloc_count = 5'($urandom_range(5, 16));
        else if (r < 95) it.alloc_count = 5'($urandom_range(17, 31));
        else             it.alloc_count = '0;
        return it;
    endfunction

    task automatic run_phase(logic [LIM_W-1:0] lim, bit steady);
        int       counted;
        in_item_t it;
        counted = 0;
        write_total(lim);
        steady_flow = steady;
        while (counted < PHASE_ITEMS) begin
            it = random_cmd();
            if (it.cmd <= CMD_ALLOC) counted++;
            push_cmd(it);
            if ($urandom_range(0, 99) < 4) hold_until_drained();
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        push_cmd(mk(CMD_FORMAT, 0, 0));
        push_cmd(mk(CMD_TEST, 0, 0));
        push_cmd(mk(CMD_TEST, 1, 31));
        push_cmd(mk(CMD_TEST, 2, 0));
        push_cmd(mk(CMD_SET, 1023, 31));
        push_cmd(mk(CMD_TEST, 1023, 0));
        push_cmd(mk(CMD_CLEAR, 1023, 31));
        push_cmd(mk(CMD_CLEAR, 0, 0));
        push_cmd(mk(CMD_ALLOC, 1023, 0));
        push_cmd(mk(CMD_ALLOC, 0, 1));
        push_cmd(mk(CMD_ALLOC, 0, 31));
        push_cmd(mk(CMD_ALLOC, 1023, 17));
        for (int c = CMD_ALLOC + 1; c <= CMD_LAST_SPARE; c++) begin
            push_cmd(mk(c[2:0], $urandom_range(0, 1023), $urandom_range(0, 31)));
        end
        push_cmd(mk(CMD_SET, 512, 16));
        push_cmd(mk(CMD_CLEAR, 512, 15));

        write_total(11'd20);
        push_cmd(mk(CMD_FORMAT, 0, 0));
        push_cmd(mk(CMD_SET, 20, 0));
        push_cmd(mk(CMD_TEST, 1023, 0));
        push_cmd(mk(CMD_ALLOC, 0, 16));
        push_cmd(mk(CMD_ALLOC, 0, 5));
        push_cmd(mk(CMD_ALLOC, 0, 3));

        write_total(11'd0);
        push_cmd(mk(CMD_FORMAT, 0, 0));
        push_cmd(mk(CMD_TEST, 0, 0));

        run_phase(11'd2, 1'b0);
        run_phase(11'd1024, 1'b1);
        run_phase(11'd2047, 1'b0);
        run_phase(11'd37, 1'b0);
        run_phase(11'd1, 1'b0);
        run_phase(LIM_W'($urandom_range(2, 1024)), 1'b0);

        settle();
        book.flush_leftovers();
        if (book.mismatches == 0) begin
            $display("block_bitmap_allocator_top verification clean");
        end else begin
            $display("block_bitmap_allocator_top verification failed");
        end
        $finish;
    end
endmodule
